/* sv/ale_pkg.sv */
// ----------------------------------------------------------------------------
// ale_pkg
// Shared constants, command and status codes, and the control bundle that
// the list engine broadcasts to its row of entry cells.
// ----------------------------------------------------------------------------
package ale_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int POS_W  = 4;
    localparam int CNT_W  = 5;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;
    localparam int ACT_W  = 3;
    localparam int ADDR_W = 3;

    // register byte addresses
    localparam logic [ADDR_W-1:0] ADDR_CAPACITY = 3'd0;

    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FIND   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_POS  = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

    // cell update actions
    localparam logic [ACT_W-1:0] ACT_NONE   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_APPEND = 3'd1;
    localparam logic [ACT_W-1:0] ACT_INSERT = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SET    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd4;

    typedef struct packed {
        logic              en;
        logic [ACT_W-1:0]  act;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
        logic [CNT_W-1:0]  count;
    } t_ale_ctl;

endpackage

/* sv/ale_cell.sv */
// ----------------------------------------------------------------------------
// ale_cell
// One list entry. Loads the request word, takes a neighbor's word on a
// shift, and flags a match against the search word.
// ----------------------------------------------------------------------------
module ale_cell (
    input  logic                      i_clk,
    input  logic [ale_pkg::POS_W-1:0]  i_index,
    input  ale_pkg::t_ale_ctl         i_ctl,
    input  logic [ale_pkg::DATA_W-1:0] i_lower,
    input  logic [ale_pkg::DATA_W-1:0] i_upper,
    output logic [ale_pkg::DATA_W-1:0] o_entry,
    output logic                      o_match
);
    import ale_pkg::*;

    logic [DATA_W-1:0] r_entry;
    logic [DATA_W-1:0] n_entry;
    logic [CNT_W-1:0]  w_idx;

    assign w_idx = {1'b0, i_index};

    always_comb begin
        n_entry = r_entry;
        unique case (i_ctl.act)
            ACT_APPEND: begin
                if (w_idx == i_ctl.count) n_entry = i_ctl.val;
            end
            ACT_INSERT: begin
                if (i_index == i_ctl.pos) begin
                    n_entry = i_ctl.val;
                end else if (i_index > i_ctl.pos && w_idx <= i_ctl.count) begin
                    n_entry = i_lower;
                end
            end
            ACT_SET: begin
                if (i_index == i_ctl.pos) n_entry = i_ctl.val;
            end
            ACT_REMOVE: begin
                if (i_index >= i_ctl.pos && CNT_W'(w_idx + 1'b1) < i_ctl.count) begin
                    n_entry = i_upper;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_match = (r_entry == i_ctl.val) && (w_idx < i_ctl.count);

endmodule

/* sv/array_list_engine_core.sv */
// ----------------------------------------------------------------------------
// array_list_engine_core
// Ordered list of signed 32-bit words held in a row of entry cells.
// Result: registered as the request is taken, presented in the next cycle.
// Throughput: 1 request per cycle while results drain; shifts and the search
// run in parallel across the cell row, and a waiting result holds off requests.
// Reset: synchronous, clears the count and output valid, capacity to 16.
// Entry words are not reset.
// ----------------------------------------------------------------------------
module array_list_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request: [2:0] command, [6:3] position, [38:7] data_value
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,
    // result: [31:0] read_value, [35:32] found_position, [37:36] status,
    // [42:38] entry_count, [43] is_empty, [44] is_full
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ale_pkg::*;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [CNT_W-1:0]  r_cap;
    logic [CNT_W-1:0]  w_eff_cap;
    logic              r_m_valid;
    logic [47:0]       r_m_data;
    logic [47:0]       n_m_data;

    logic              w_accept;
    logic [CMD_W-1:0]  w_cmd;
    logic [POS_W-1:0]  w_pos;
    logic [DATA_W-1:0] w_val;
    logic [CNT_W-1:0]  w_pos_ext;
    logic              w_full;

    t_ale_ctl          w_ctl;
    logic [ACT_W-1:0]  w_act;
    logic [STAT_W-1:0] w_status;
    logic [DATA_W-1:0] w_rd;
    logic [POS_W-1:0]  w_found;
    logic              w_any;
    logic [POS_W-1:0]  w_first;

    logic [DATA_W-1:0] w_entry [DEPTH];
    logic [DEPTH-1:0]  w_match;

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CAPACITY) ? {{(32-CNT_W){1'b0}}, r_cap} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CNT_W'(DEPTH);
        end else if (psel && penable && pwrite && pready && paddr == ADDR_CAPACITY) begin
            r_cap <= pwdata[CNT_W-1:0];
        end
    end

    assign w_eff_cap = (r_cap > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : r_cap;

    // request decode
    assign s_tready  = !r_m_valid || m_tready;
    assign w_accept  = s_tvalid && s_tready;
    assign w_cmd     = s_tdata[2:0];
    assign w_pos     = s_tdata[6:3];
    assign w_val     = s_tdata[38:7];
    assign w_pos_ext = {1'b0, w_pos};
    assign w_full    = r_count >= w_eff_cap;

    // first match in the row
    always_comb begin
        w_any   = 1'b0;
        w_first = '0;
        for (int k = DEPTH - 1; k >= 0; k--) begin
            if (w_match[k]) begin
                w_any   = 1'b1;
                w_first = POS_W'(k);
            end
        end
    end

    always_comb begin
        w_act    = ACT_NONE;
        w_status = ST_OK;
        w_rd     = '0;
        w_found  = '0;
        n_count  = r_count;
        unique case (w_cmd)
            CMD_APPEND: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_act   = ACT_APPEND;
                    n_count = CNT_W'(r_count + 1'b1);
                end
            end
            CMD_INSERT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else if (w_pos_ext > r_count) begin
                    w_status = ST_BAD_POS;
                end else begin
                    w_act   = ACT_INSERT;
                    n_count = CNT_W'(r_count + 1'b1);
                end
            end
            CMD_GET: begin
                if (w_pos_ext >= r_count) w_status = ST_BAD_POS;
                else                      w_rd     = w_entry[w_pos];
            end
            CMD_SET: begin
                if (w_pos_ext >= r_count) w_status = ST_BAD_POS;
                else                      w_act    = ACT_SET;
            end
            CMD_FIND: begin
                if (w_any) w_found  = w_first;
                else       w_status = ST_NOT_FOUND;
            end
            CMD_REMOVE: begin
                if (w_pos_ext >= r_count) begin
                    w_status = ST_BAD_POS;
                end else begin
                    w_act   = ACT_REMOVE;
                    n_count = CNT_W'(r_count - 1'b1);
                end
            end
            default: begin
                w_act = ACT_NONE;
            end
        endcase
    end

    assign w_ctl.en    = w_accept;
    assign w_ctl.act   = w_act;
    assign w_ctl.pos   = w_pos;
    assign w_ctl.val   = w_val;
    assign w_ctl.count = r_count;

    // cell row
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] w_lower;
        logic [DATA_W-1:0] w_upper;

        if (g == 0) begin : g_lo
            assign w_lower = '0;
        end else begin : g_lo
            assign w_lower = w_entry[g-1];
        end
        if (g == DEPTH - 1) begin : g_hi
            assign w_upper = '0;
        end else begin : g_hi
            assign w_upper = w_entry[g+1];
        end

        ale_cell u_cell (
            .i_clk   (i_clk),
            .i_index (POS_W'(g)),
            .i_ctl   (w_ctl),
            .i_lower (w_lower),
            .i_upper (w_upper),
            .o_entry (w_entry[g]),
            .o_match (w_match[g])
        );
    end

    // result register
    always_comb begin
        n_m_data        = '0;
        n_m_data[31:0]  = w_rd;
        n_m_data[35:32] = w_found;
        n_m_data[37:36] = w_status;
        n_m_data[42:38] = n_count;
        n_m_data[43]    = (n_count == '0);
        n_m_data[44]    = (n_count >= w_eff_cap);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count   <= n_count;
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) r_m_data <= n_m_data;
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;

endmodule
